// ===== src/debounced_key_press_detector_top_assert.svh =====
// assertion macros for the debounced key press detector
`ifndef DEBOUNCED_KEY_PRESS_DETECTOR_TOP_ASSERT_SVH
`define DEBOUNCED_KEY_PRESS_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DKPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define DKPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== src/dkpd_pkg.sv =====
// types and constants for the debounced key press detector
package dkpd_pkg;

   localparam logic [7:0] STATUS_PRESSED  = 8'hC8;
   localparam logic [7:0] STATUS_RELEASED = 8'h00;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_RESYNC = 1'b1;

   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

   localparam logic MODE_SWITCH     = 1'b0;
   localparam logic MODE_PUSHBUTTON = 1'b1;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESS_MODE    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOCKED        = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_MS   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_MS = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHANNEL_ID    = 3'd4;

   localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

   typedef struct packed {
      logic       event_valid;
      logic       event_long;
      logic [7:0] event_count;
      logic [7:0] event_channel;
      logic [7:0] status_value;
   } rsp_type;

endpackage

// ===== src/debounced_key_press_detector_top.sv =====
// debounced key press detector with long-press repeat, single pass per transaction
// an accepted request is held in the input register, and its result is then captured in the result register
// throughput: one transaction per cycle while results are taken, set by the single registered compute stage
// the input register stalls only while the result register holds an untaken result
// reset (synchronous, active high) restores the configuration, state and valid registers to defaults
module debounced_key_press_detector_top #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [39:0]                        req_tdata,  // time_ms, pin_level, zero pad
   input  logic                               req_tuser,  // op
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,  // event_count, event_channel,
                                                          // status_value
   output logic [1:0]                         rsp_tuser,  // event_valid, event_long
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dkpd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dkpd_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   logic                  press_mode_ff;
   logic                  locked_ff;
   logic [15:0]           debounce_ff;
   logic [15:0]           long_press_ff;
   logic [7:0]            channel_ff;

   logic                  raw_level_ff, raw_level_in;
   logic                  stable_level_ff, stable_level_in;
   logic [TIME_WIDTH-1:0] change_time_ff, change_time_in;
   logic [TIME_WIDTH-1:0] press_start_ff, press_start_in;
   logic [TIME_WIDTH-1:0] last_long_ff, last_long_in;
   logic [7:0]            counter_ff, counter_in;
   logic                  long_reported_ff, long_reported_in;

   logic                  s1_valid_ff;
   logic                  s1_op_ff;
   logic [TIME_WIDTH-1:0] s1_time_ff;
   logic                  s1_pin_ff;

   logic                  rsp_valid_ff;
   dkpd_pkg::rsp_type     rsp_ff, rsp_in;

   logic                  s1_advance;
   logic                  ev_short;
   logic [TIME_WIDTH-1:0] since_change, since_press, since_long;

   assign csr_ready  = 1'b1;
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_mode_ff <= dkpd_pkg::MODE_PUSHBUTTON;
         locked_ff     <= 1'b0;
         debounce_ff   <= dkpd_pkg::DEBOUNCE_RESET;
         long_press_ff <= dkpd_pkg::LONG_PRESS_RESET;
         channel_ff    <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dkpd_pkg::CSR_PRESS_MODE:    press_mode_ff <= csr_data[0];
            dkpd_pkg::CSR_LOCKED:        locked_ff     <= csr_data[0];
            dkpd_pkg::CSR_DEBOUNCE_MS:   debounce_ff   <= csr_data;
            dkpd_pkg::CSR_LONG_PRESS_MS: long_press_ff <= csr_data;
            dkpd_pkg::CSR_CHANNEL_ID:    channel_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign since_change = s1_time_ff - change_time_ff;
   assign since_press  = s1_time_ff - press_start_ff;
   assign since_long   = s1_time_ff - last_long_ff;

   always_comb begin
      raw_level_in     = raw_level_ff;
      stable_level_in  = stable_level_ff;
      change_time_in   = change_time_ff;
      press_start_in   = press_start_ff;
      last_long_in     = last_long_ff;
      counter_in       = counter_ff;
      long_reported_in = long_reported_ff;
      ev_short         = 1'b0;
      rsp_in           = '0;
      if (s1_op_ff == dkpd_pkg::OP_RESYNC) begin
         raw_level_in     = s1_pin_ff;
         stable_level_in  = s1_pin_ff;
         change_time_in   = s1_time_ff;
         long_reported_in = 1'b0;
      end else if (s1_pin_ff != raw_level_ff) begin
         raw_level_in   = s1_pin_ff;
         change_time_in = s1_time_ff;
      end else if (since_change >= TIME_WIDTH'(debounce_ff)) begin
         stable_level_in = s1_pin_ff;
         if (!locked_ff) begin
            if (press_mode_ff == dkpd_pkg::MODE_SWITCH) begin
               if (s1_pin_ff != stable_level_ff) begin
                  ev_short = 1'b1;
               end
            end else if (s1_pin_ff != stable_level_ff) begin
               if (s1_pin_ff == dkpd_pkg::LEVEL_PRESSED) begin
                  press_start_in   = s1_time_ff;
                  long_reported_in = 1'b0;
               end else if (!long_reported_ff) begin
                  ev_short = 1'b1;
               end
            end else if (s1_pin_ff == dkpd_pkg::LEVEL_PRESSED) begin
               if (!long_reported_ff) begin
                  if (since_press >= TIME_WIDTH'(long_press_ff)) begin
                     long_reported_in  = 1'b1;
                     last_long_in      = s1_time_ff;
                     rsp_in.event_valid = 1'b1;
                     rsp_in.event_long  = 1'b1;
                  end
               end else if (since_long >= TIME_WIDTH'(long_press_ff >> 1)) begin
                  last_long_in       = s1_time_ff;
                  rsp_in.event_valid = 1'b1;
                  rsp_in.event_long  = 1'b1;
               end
            end
         end
      end
      if (ev_short) begin
         rsp_in.event_valid = 1'b1;
         counter_in         = counter_ff + 8'd1;
      end
      if (rsp_in.event_valid) begin
         rsp_in.event_count   = counter_ff;
         rsp_in.event_channel = channel_ff;
      end
      rsp_in.status_value = (stable_level_in == dkpd_pkg::LEVEL_RELEASED) ?
                            dkpd_pkg::STATUS_RELEASED : dkpd_pkg::STATUS_PRESSED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         raw_level_ff     <= dkpd_pkg::LEVEL_RELEASED;
         stable_level_ff  <= dkpd_pkg::LEVEL_RELEASED;
         change_time_ff   <= '0;
         press_start_ff   <= '0;
         last_long_ff     <= '0;
         counter_ff       <= 8'd0;
         long_reported_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s1_advance) begin
            rsp_valid_ff     <= 1'b1;
            raw_level_ff     <= raw_level_in;
            stable_level_ff  <= stable_level_in;
            change_time_ff   <= change_time_in;
            press_start_ff   <= press_start_in;
            last_long_ff     <= last_long_in;
            counter_ff       <= counter_in;
            long_reported_ff <= long_reported_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_op_ff   <= req_tuser;
         s1_time_ff <= req_tdata[TIME_WIDTH-1:0];
         s1_pin_ff  <= req_tdata[32];
      end
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.event_long, rsp_ff.event_valid};
   assign rsp_tdata  = {rsp_ff.status_value, rsp_ff.event_channel, rsp_ff.event_count};

`include "debounced_key_press_detector_top_assert.svh"

   `DKPD_ASSERT_NOW(a_no_event_fields_clear, clock, reset,
      rsp_valid_ff && !rsp_ff.event_valid,
      !rsp_ff.event_long && rsp_ff.event_count == 8'd0 && rsp_ff.event_channel == 8'd0)
   `DKPD_ASSERT_NEXT(a_short_event_counts, clock, reset,
      s1_advance && ev_short, counter_ff == $past(counter_ff) + 8'd1)
   `DKPD_ASSERT_NEXT(a_locked_silent, clock, reset,
      s1_advance && locked_ff, !rsp_ff.event_valid)
   `DKPD_ASSERT_NEXT(a_status_tracks_level, clock, reset,
      s1_advance,
      rsp_ff.status_value == ((stable_level_ff == dkpd_pkg::LEVEL_RELEASED) ?
                              dkpd_pkg::STATUS_RELEASED : dkpd_pkg::STATUS_PRESSED))

endmodule
